FILE: rtl/core/bus_pkg.sv
// Shared constants, codes and types for the bounded unique set.
package bus_pkg;

  localparam int unsigned CAPACITY      = 8;
  localparam int unsigned VALUE_WIDTH   = 32;
  localparam int unsigned CNT_W         = $clog2(CAPACITY + 1);
  localparam int unsigned IDX_W         = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

  localparam int unsigned CMD_W         = 2;
  localparam int unsigned ELEM_W        = 32;
  localparam int unsigned STATUS_W      = 2;
  localparam int unsigned ENTRY_COUNT_W = 4;

  localparam int unsigned IN_DATA_W     = 40;
  localparam int unsigned OUT_DATA_W    = 8;

  localparam logic [CMD_W-1:0] CMD_ADD      = 2'd0;
  localparam logic [CMD_W-1:0] CMD_REMOVE   = 2'd1;
  localparam logic [CMD_W-1:0] CMD_CONTAINS = 2'd2;
  localparam logic [CMD_W-1:0] CMD_CLEAR    = 2'd3;

  localparam logic [STATUS_W-1:0] ST_DONE      = 2'd0;
  localparam logic [STATUS_W-1:0] ST_DUPLICATE = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL      = 2'd2;
  localparam logic [STATUS_W-1:0] ST_ABSENT    = 2'd3;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;    // capture the incoming item
    logic commit;  // apply the update and load the result register
  } bus_ctrl_t;

endpackage

FILE: rtl/core/bus_ctrl.sv
// Controller state machine: input handshake, execute sequencing, result valid.
module bus_ctrl
  import bus_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output bus_ctrl_t ctrl_o
);

  localparam logic S_IDLE = 1'b0;
  localparam logic S_EXEC = 1'b1;

  logic state_q, state_d;
  logic out_valid_q, out_valid_d;
  logic out_free;

  assign out_free   = !out_valid_q || out_ready_i;
  assign in_ready_o = (state_q == S_IDLE);

  always_comb begin
    state_d       = state_q;
    out_valid_d   = out_valid_q;
    ctrl_o.load   = 1'b0;
    ctrl_o.commit = 1'b0;
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          ctrl_o.load = 1'b1;
          state_d     = S_EXEC;
        end
      end
      S_EXEC: begin
        // Hold the item until the result register can take its result.
        if (out_free) begin
          ctrl_o.commit = 1'b1;
          out_valid_d   = 1'b1;
          state_d       = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

FILE: rtl/core/bus_datapath.sv
// Datapath: entry registers, parallel compare, update and result register.
module bus_datapath
  import bus_pkg::*;
(
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  bus_ctrl_t                ctrl_i,
  input  logic [CMD_W-1:0]         command_i,
  input  logic [ELEM_W-1:0]        element_value_i,
  output logic [STATUS_W-1:0]      status_o,
  output logic                     present_o,
  output logic [ENTRY_COUNT_W-1:0] entry_count_o
);

  logic [CMD_W-1:0]       cmd_q;
  logic [VALUE_WIDTH-1:0] value_q;
  logic [VALUE_WIDTH-1:0] entries_q [CAPACITY];
  logic [CNT_W-1:0]       count_q, count_d;

  logic [STATUS_W-1:0]      status_q, status_d;
  logic                     present_q, present_d;
  logic [ENTRY_COUNT_W-1:0] entry_count_q;

  logic [CAPACITY-1:0] match;
  logic                hit;
  logic [IDX_W-1:0]    slot;
  logic [CNT_W-1:0]    last_cnt;
  logic [IDX_W-1:0]    last_idx;
  logic                full;
  logic                wr_en;
  logic [IDX_W-1:0]    wr_idx;
  logic [VALUE_WIDTH-1:0] wr_data;

  // One comparator per entry; only entries below the count take part.
  always_comb begin
    for (int i = 0; i < CAPACITY; i++) begin
      match[i] = (CNT_W'(i) < count_q) && (entries_q[i] == value_q);
    end
  end

  // Lowest matching entry.
  always_comb begin
    slot = '0;
    for (int i = CAPACITY - 1; i >= 0; i--) begin
      if (match[i]) begin
        slot = IDX_W'(i);
      end
    end
  end

  assign hit      = |match;
  assign full     = (count_q == CNT_W'(CAPACITY));
  assign last_cnt = count_q - CNT_W'(1);
  assign last_idx = last_cnt[IDX_W-1:0];

  always_comb begin
    count_d   = count_q;
    status_d  = ST_DONE;
    present_d = hit;
    wr_en     = 1'b0;
    wr_idx    = count_q[IDX_W-1:0];
    wr_data   = value_q;
    unique case (cmd_q)
      CMD_ADD: begin
        if (hit) begin
          status_d = ST_DUPLICATE;
        end else if (full) begin
          status_d = ST_FULL;
        end else begin
          wr_en   = 1'b1;
          count_d = count_q + CNT_W'(1);
        end
      end
      CMD_REMOVE: begin
        if (hit) begin
          // The last entry moves into the freed slot.
          wr_en   = 1'b1;
          wr_idx  = slot;
          wr_data = entries_q[last_idx];
          count_d = last_cnt;
        end else begin
          status_d = ST_ABSENT;
        end
      end
      CMD_CONTAINS: begin
        status_d = hit ? ST_DONE : ST_ABSENT;
      end
      CMD_CLEAR: begin
        count_d   = '0;
        present_d = 1'b0;
      end
      default: status_d = ST_DONE;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.load) begin
      cmd_q   <= command_i;
      value_q <= VALUE_WIDTH'(element_value_i);
    end
    if (ctrl_i.commit) begin
      if (wr_en) begin
        entries_q[wr_idx] <= wr_data;
      end
      status_q      <= status_d;
      present_q     <= present_d;
      entry_count_q <= ENTRY_COUNT_W'(count_d);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else if (ctrl_i.commit) begin
      count_q <= count_d;
    end
  end

  assign status_o      = status_q;
  assign present_o     = present_q;
  assign entry_count_o = entry_count_q;

endmodule

FILE: rtl/core/bounded_unique_set_top.sv
// Top level of the bounded unique set: stream ports, controller and datapath.
//
// The block holds a set of up to CAPACITY distinct values and executes one
// command per input item: add, remove, contains or clear. Every item yields
// exactly one result item carrying a status, a flag that tells whether the
// value was in the set before the command (zero for clear), and the entry
// count afterwards. Add stores a value only if it is absent and there is
// room; remove fills the freed slot with the last entry so that the stored
// entries stay packed. An item is first captured; then, in the execute
// state, all entries are compared against the value in parallel and the
// set is updated, and no new item is taken meanwhile. A new item is taken
// while the previous result still waits on the output; the block only
// stalls in its execute state when that earlier result has not yet been
// taken. After reset the set is empty and the block is ready at once.
module bounded_unique_set_top
  import bus_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  // Fields from bit 0: command[1:0], element_value[33:2], zero fill[39:34].
  input  logic [IN_DATA_W-1:0]  s_axis_tdata,
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  // Fields from bit 0: status[1:0], present[2], entry_count[6:3], zero fill[7].
  output logic [OUT_DATA_W-1:0] m_axis_tdata
);

  bus_ctrl_t                ctrl;
  logic [STATUS_W-1:0]      status;
  logic                     present;
  logic [ENTRY_COUNT_W-1:0] entry_count;

  // The controller owns both handshakes and tells the datapath when to
  // capture an item and when to commit its result.
  bus_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .ctrl_o      (ctrl)
  );

  bus_datapath u_datapath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .ctrl_i          (ctrl),
    .command_i       (s_axis_tdata[1:0]),
    .element_value_i (s_axis_tdata[33:2]),
    .status_o        (status),
    .present_o       (present),
    .entry_count_o   (entry_count)
  );

  // The result register sits in the datapath, so the output is stable
  // while a result waits to be taken.
  assign m_axis_tdata = {1'b0, entry_count, present, status};

endmodule

FILE: rtl/core/bus_checker.sv
// Port-level checker for the bounded unique set and its bind to the top level.
module bus_checker
  import bus_pkg::*;
(
  input logic                  clk_i,
  input logic                  rst_ni,
  input logic                  s_axis_tvalid,
  input logic                  s_axis_tready,
  input logic [IN_DATA_W-1:0]  s_axis_tdata,
  input logic                  m_axis_tvalid,
  input logic                  m_axis_tready,
  input logic [OUT_DATA_W-1:0] m_axis_tdata
);

  // A waiting result is held unchanged.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result changed while stalled");

  // The count never exceeds the capacity.
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (CAPACITY > 15) || (m_axis_tdata[6:3] <= 4'(CAPACITY)))
    else $error("entry count above capacity");

  // A full report means the value was absent and the set is at capacity.
  a_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[1:0] == ST_FULL
      |-> !m_axis_tdata[2] && m_axis_tdata[6:3] == 4'(CAPACITY))
    else $error("full status inconsistent");

  // A duplicate report always comes with the present flag.
  a_dup: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[1:0] == ST_DUPLICATE |-> m_axis_tdata[2])
    else $error("duplicate without present flag");

  // An accepted item cannot be followed by another in the very next cycle.
  a_rate: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("input taken during execute");

endmodule

bind bounded_unique_set_top bus_checker u_bus_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .s_axis_tdata  (s_axis_tdata),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);
